/* rtl/core/zpd_pkg.sv */
// ----------------------------------------------------------------------------
// zpd_pkg
// Shared types and constants of the z-score peak detector.
// ----------------------------------------------------------------------------
package zpd_pkg;

  localparam int unsigned MaxWindowDef  = 64;
  localparam int unsigned SampleBitsDef = 16;
  localparam int unsigned QBits         = 24;
  localparam int unsigned SdBits        = 23;
  localparam int unsigned LagBits       = 6;
  localparam int unsigned ThrBits       = 16;
  localparam int unsigned InfBits       = 17;
  localparam int unsigned CountBits     = 7;
  localparam int unsigned CfgIdxBits    = 2;
  localparam int unsigned CfgDataBits   = 17;

  localparam logic [CfgIdxBits-1:0] CfgLag = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgThr = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgInf = 2'd2;

  localparam logic [LagBits-1:0] LagReset = 6'd30;
  localparam logic [ThrBits-1:0] ThrReset = 16'd1280;
  localparam logic [InfBits-1:0] InfReset = 17'd0;
  localparam logic [InfBits-1:0] InfOne   = 17'd65536;

  localparam logic [1:0] SigPos  = 2'b01;
  localparam logic [1:0] SigNeg  = 2'b11;
  localparam logic [1:0] SigNone = 2'b00;

  typedef struct packed {
    logic [1:0]         peak_signal;
    logic [QBits-1:0]   window_mean;
    logic [SdBits-1:0]  window_stddev;
    logic               stats_valid;
  } zpd_result_t;

endpackage

/* rtl/core/zpd_stream_if.sv */
// ----------------------------------------------------------------------------
// zpd_stream_if
// Valid/ready channel carrying one word of a generic payload.
// ----------------------------------------------------------------------------
interface zpd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/zscore_peak_detector_unit.sv */
// ----------------------------------------------------------------------------
// zscore_peak_detector_unit
// Smoothed z-score peak detector: ring of filtered Q16.8 samples, window
// mean and deviation from a sequenced shared add/divide/root datapath.
//
//  channel  dir  payload
//  in_s     in   sample[SampleBits], first
//  out_s    out  peak_signal, window_mean, window_stddev, stats_valid
//  cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i
//
// A word is accepted only in StIdle, so the next is taken once this one has
// left StDone; a blended peak adds a StBlend step. The sum and square passes
// read the window's n ring entries (n = window length) one per cycle, a
// 57-step restoring divider runs twice, then a 29-step root. Warm-up words
// go from StWrite to StDone. Reset clears control and stats; the ring is
// undefined until written. A result waits in the output register while the
// next word runs; that word holds in StDone until the register frees.
// ----------------------------------------------------------------------------
module zscore_peak_detector_unit
  import zpd_pkg::*;
#(
  parameter int unsigned MaxWindow  = MaxWindowDef,
  parameter int unsigned SampleBits = SampleBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  zpd_stream_if.sink             in_s,
  zpd_stream_if.source           out_s,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i
);

  localparam int unsigned AddrBits = $clog2(MaxWindow);
  localparam int unsigned NBits    = $clog2(MaxWindow + 1);
  localparam int unsigned SumBits  = QBits + NBits + 1;
  localparam int unsigned SqBits   = 2 * QBits + NBits + 2;
  localparam int unsigned DivBits  = SqBits;
  localparam int unsigned DivCntW  = $clog2(DivBits + 1);
  localparam int unsigned RootBits = SqBits / 2 + 1;
  localparam int unsigned RootCntW = $clog2(RootBits + 1);

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StBlend = 9'b000000010,
    StWrite = 9'b000000100,
    StSum   = 9'b000001000,
    StDivM  = 9'b000010000,
    StSq    = 9'b000100000,
    StDivV  = 9'b001000000,
    StRoot  = 9'b010000000,
    StDone  = 9'b100000000
  } state_e;

  state_e state_q;

  logic [LagBits-1:0] lag_q;
  logic [ThrBits-1:0] thr_q;
  logic [InfBits-1:0] inf_q;

  logic [QBits-1:0] mem_q [MaxWindow];
  logic [QBits-1:0] rd_q;
  logic [AddrBits-1:0] rd_addr;
  logic             mem_we;
  logic [AddrBits-1:0] widx_q;
  logic [CountBits-1:0] cnt_q;
  logic signed [QBits-1:0] lmean_q, x_q, stored_q, mean_q;
  logic [QBits-1:0] lsd_q;
  logic [NBits-1:0] n_q, k_q;
  logic             rd_live_q;
  logic [1:0]       sig_q;
  logic signed [SumBits-1:0] sum_q;
  logic [SqBits-1:0] sq_q;
  logic              neg_q;
  logic [DivBits-1:0] quo_q, rem_q;
  logic [DivCntW-1:0] dcnt_q;
  logic [SqBits-1:0]  rv_q;
  logic [SqBits-1:0]  rr_q;
  logic [RootCntW-1:0] rcnt_q;
  zpd_result_t res_q;
  logic        out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lag_q <= LagReset;
      thr_q <= ThrReset;
      inf_q <= InfReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgLag:  lag_q <= cfg_data_i[LagBits-1:0];
        CfgThr:  thr_q <= cfg_data_i[ThrBits-1:0];
        CfgInf:  inf_q <= cfg_data_i[InfBits-1:0];
        default: ;
      endcase
    end
  end

  // Input conversion to Q16.8 with saturation
  logic signed [SampleBits-1:0] smp;
  logic signed [SampleBits+8:0] smp_q8;
  logic signed [QBits-1:0] x_sat;
  assign smp    = in_s.data[SampleBits:1];
  assign smp_q8 = {smp[SampleBits-1], smp, 8'd0};
  always_comb begin
    if (smp_q8 > 64'sd8388607)
      x_sat = 24'sh7FFFFF;
    else if (smp_q8 < -64'sd8388608)
      x_sat = -24'sh800000;
    else
      x_sat = QBits'(smp_q8);
  end

  logic first_in;
  assign first_in = in_s.data[0];

  logic in_fire, out_fire, done_go;
  assign in_s.ready = (state_q == StIdle);
  assign in_fire    = in_s.valid && in_s.ready;
  assign out_fire   = out_s.valid && out_s.ready;
  assign done_go    = (state_q == StDone) && (!out_valid_q || out_fire);

  // Effective series state at accept
  logic [AddrBits-1:0] widx_e;
  logic [CountBits-1:0] cnt_e;
  logic signed [QBits-1:0] lmean_e;
  logic [QBits-1:0] lsd_e;
  assign widx_e  = first_in ? '0 : widx_q;
  assign cnt_e   = first_in ? '0 : cnt_q;
  assign lmean_e = first_in ? '0 : lmean_q;
  assign lsd_e   = first_in ? '0 : lsd_q;

  // Peak test
  logic signed [QBits:0] dlt;
  logic [QBits:0] dmag;
  logic [QBits+8:0] mag;
  logic [ThrBits+QBits-1:0] lim;
  logic peak_hit;
  assign dlt  = (QBits+1)'(x_sat) - (QBits+1)'(lmean_e);
  assign dmag = dlt[QBits] ? (QBits+1)'(-dlt) : (QBits+1)'(dlt);
  assign mag  = {dmag, 8'd0};
  assign lim  = thr_q * lsd_e;
  assign peak_hit = ({7'd0, cnt_e} > {7'd0, {(CountBits-LagBits){1'b0}}, lag_q}) &&
                    ((ThrBits+QBits+1)'(mag) > (ThrBits+QBits+1)'(lim));

  // Blend: weighted sum of two products, registered into stored_q
  logic [InfBits-1:0] inf_c;
  logic [InfBits:0] inf_w;
  logic signed [QBits+InfBits+2:0] blend_sum, blend_fl;
  logic signed [QBits-1:0] blend_sat;
  assign inf_c = (inf_q > InfOne) ? InfOne : inf_q;
  assign inf_w = {1'b0, inf_c};
  assign blend_sum = $signed({1'b0, inf_w}) * x_q +
                     $signed({1'b0, (InfBits+1)'(InfOne) - inf_w}) * $signed(rd_q);
  assign blend_fl  = blend_sum >>> 16;
  always_comb begin
    if (blend_fl > $signed((QBits+InfBits+3)'(8388607)))
      blend_sat = 24'sh7FFFFF;
    else if (blend_fl < -$signed((QBits+InfBits+3)'(8388608)))
      blend_sat = -24'sh800000;
    else
      blend_sat = QBits'(blend_fl);
  end

  // Ring read address: k entries back from the newest
  logic [AddrBits-1:0] prev_addr;
  logic [AddrBits:0]   rd_back;
  assign prev_addr = (widx_e == '0) ? AddrBits'(MaxWindow - 1) : widx_e - AddrBits'(1);
  always_comb begin
    rd_back = {1'b0, widx_q} - (AddrBits+1)'(k_q);
    rd_addr = rd_back[AddrBits] ? AddrBits'(rd_back + (AddrBits+1)'(MaxWindow))
                                : AddrBits'(rd_back);
    if (state_q == StIdle) rd_addr = prev_addr;
  end
  assign mem_we = (state_q == StWrite);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[widx_q] <= stored_q;
    rd_q <= mem_q[rd_addr];
  end

  // Shared restoring divider step
  logic [DivBits:0] rem_sh;
  logic [DivBits:0] dvs;
  logic div_ge;
  assign rem_sh = {rem_q, quo_q[DivBits-1]};
  assign dvs    = (DivBits+1)'(n_q);
  assign div_ge = rem_sh >= dvs;

  // Root step
  logic [SqBits-1:0] rtrial;
  logic [SqBits-1:0] rbit;
  assign rbit   = SqBits'(1) << (2 * (rcnt_q - RootCntW'(1)));
  assign rtrial = rr_q + rbit;

  logic signed [QBits:0] dev;
  logic [2*QBits+1:0] dev_sq;
  logic signed [SumBits-1:0] mean_sum;
  assign dev      = $signed({rd_q[QBits-1], rd_q}) - $signed({mean_q[QBits-1], mean_q});
  assign dev_sq   = (2*QBits+2)'(dev * dev);
  assign mean_sum = sum_q + SumBits'($signed(rd_q));

  logic signed [DivBits:0] q_signed;
  assign q_signed = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

  logic [LagBits:0] n_raw;
  assign n_raw = {1'b0, lag_q} + (LagBits+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      widx_q      <= '0;
      cnt_q       <= '0;
      lmean_q     <= '0;
      lsd_q       <= '0;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      dcnt_q      <= '0;
      rcnt_q      <= '0;
      rd_live_q   <= 1'b0;
    end else begin
      if (done_go) out_valid_q <= 1'b1;
      else if (out_fire) out_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (in_fire) begin
            widx_q  <= widx_e;
            cnt_q   <= cnt_e;
            lmean_q <= lmean_e;
            lsd_q   <= lsd_e;
            x_q     <= x_sat;
            stored_q <= x_sat;
            sig_q   <= peak_hit ? ((x_sat > lmean_e) ? SigPos : SigNeg) : SigNone;
            n_q     <= (32'(n_raw) > MaxWindow) ? NBits'(MaxWindow) : NBits'(n_raw);
            state_q <= peak_hit ? StBlend : StWrite;
          end
        end
        StBlend: begin
          stored_q <= blend_sat;
          state_q  <= StWrite;
        end
        StWrite: begin
          sum_q <= '0;
          sq_q  <= '0;
          k_q   <= '0;
          rd_live_q <= 1'b0;
          if ({{(CountBits-LagBits){1'b0}}, lag_q} <= cnt_q) state_q <= StSum;
          else begin
            mean_q <= '0;
            rv_q   <= '0;
            rr_q   <= '0;
            state_q <= StDone;
          end
        end
        StSum: begin
          if (rd_live_q) sum_q <= mean_sum;
          if (k_q == n_q) begin
            state_q <= StDivM;
            dcnt_q <= DivCntW'(DivBits);
            rem_q  <= '0;
            quo_q  <= DivBits'(mean_sum[SumBits-1] ? SumBits'(-mean_sum) : mean_sum);
            neg_q  <= mean_sum[SumBits-1];
            rd_live_q <= 1'b0;
          end else begin
            k_q <= k_q + NBits'(1);
            rd_live_q <= 1'b1;
          end
        end
        StDivM: begin
          if (dcnt_q != '0) begin
            rem_q  <= div_ge ? DivBits'(rem_sh - dvs) : DivBits'(rem_sh);
            quo_q  <= {quo_q[DivBits-2:0], div_ge};
            dcnt_q <= dcnt_q - DivCntW'(1);
          end else begin
            if (q_signed > $signed((DivBits+1)'(8388607)))
              mean_q <= 24'sh7FFFFF;
            else if (q_signed < -$signed((DivBits+1)'(8388608)))
              mean_q <= -24'sh800000;
            else
              mean_q <= QBits'(q_signed);
            k_q <= '0;
            rd_live_q <= 1'b0;
            state_q <= StSq;
          end
        end
        StSq: begin
          if (rd_live_q) sq_q <= sq_q + SqBits'(dev_sq);
          if (k_q == n_q) begin
            quo_q  <= sq_q + SqBits'(dev_sq);
            rem_q  <= '0;
            dcnt_q <= DivCntW'(DivBits);
            state_q <= StDivV;
          end else begin
            k_q <= k_q + NBits'(1);
            rd_live_q <= 1'b1;
          end
        end
        StDivV: begin
          if (dcnt_q != '0) begin
            rem_q  <= div_ge ? DivBits'(rem_sh - dvs) : DivBits'(rem_sh);
            quo_q  <= {quo_q[DivBits-2:0], div_ge};
            dcnt_q <= dcnt_q - DivCntW'(1);
          end else begin
            rv_q   <= quo_q;
            rr_q   <= '0;
            rcnt_q <= RootCntW'(RootBits);
            state_q <= StRoot;
          end
        end
        StRoot: begin
          if (rcnt_q != '0) begin
            if (rv_q >= rtrial) begin
              rv_q <= rv_q - rtrial;
              rr_q <= (rr_q >> 1) + rbit;
            end else begin
              rr_q <= rr_q >> 1;
            end
            rcnt_q <= rcnt_q - RootCntW'(1);
          end else begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (done_go) begin
            res_q.peak_signal   <= sig_q;
            res_q.stats_valid   <= ({{(CountBits-LagBits){1'b0}}, lag_q} <= cnt_q);
            res_q.window_mean   <= mean_q;
            res_q.window_stddev <= (rr_q > SqBits'(8388607)) ? SdBits'(8388607)
                                                             : SdBits'(rr_q);
            if ({{(CountBits-LagBits){1'b0}}, lag_q} <= cnt_q) begin
              lmean_q <= mean_q;
              lsd_q   <= (rr_q > SqBits'(8388607)) ? QBits'(8388607) : QBits'(rr_q);
            end
            widx_q <= (widx_q == AddrBits'(MaxWindow - 1)) ? '0 : widx_q + AddrBits'(1);
            if (cnt_q != {CountBits{1'b1}}) cnt_q <= cnt_q + CountBits'(1);
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_s.valid = out_valid_q;
  assign out_s.data  = res_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_s.ready)
    else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_s.ready) |=> out_valid_q)
    else $error("result dropped");
  a_warmup_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.stats_valid) |-> (res_q.window_mean == '0 &&
      res_q.window_stddev == '0 && res_q.peak_signal == SigNone))
    else $error("warm-up result not zero");

endmodule

/* test/tb_zscore_peak_detector_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_zscore_peak_detector_unit
// Self-checking bench for the z-score peak detector. A table of directed
// words, then series of noisy samples with spikes under several register
// settings, all on randomly idling valid/ready channels. Each result word
// is compared field by field with a fixed-point software model or a typed table row.
// ----------------------------------------------------------------------------
module tb_zscore_peak_detector_unit;
  import zpd_pkg::*;

  typedef struct packed {
    logic [SampleBitsDef-1:0] sample;
    logic                     first;
  } sample_word_t;

  typedef struct {
    int          sample;
    bit          first;
    bit          typed;
    zpd_result_t result;
  } directed_row_t;

  localparam int unsigned RingDepth = MaxWindowDef;
  localparam int unsigned SettleCycles = 300;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_data_i;

  zpd_stream_if #(.payload_t(sample_word_t)) in_s ();
  zpd_stream_if #(.payload_t(zpd_result_t))  out_s ();

  zscore_peak_detector_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_s       (in_s),
    .out_s      (out_s),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // filter state mirrored by the bench
  logic signed [QBits-1:0] filt_ring [RingDepth];
  int unsigned   ring_wr;
  int unsigned   series_idx;
  longint        held_mean;
  longint        held_sd;
  int unsigned   lag_cfg;
  longint        thr_cfg;
  longint        inf_cfg;

  zpd_result_t pending_results[$];
  int          error_count;
  int          words_checked;
  int          pos_peaks;
  int          neg_peaks;
  int          stats_words;
  int          hold_request;
  bit          send_quiet;

  directed_row_t directed_rows[$];

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  initial begin
    #40_000_000;
    $display("tb_zscore_peak_detector_unit: done, errors");
    $finish;
  end

  task automatic flag_mismatch(string what, longint got, longint want);
    error_count++;
    $display("mismatch at word %0d: %s got %0d expected %0d", words_checked, what, got, want);
  endtask

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic zpd_result_t next_peak_result(logic [SampleBitsDef-1:0] smp, bit first);
    zpd_result_t res;
    longint x;
    longint stored;
    longint diff;
    longint unsigned mag;
    longint unsigned lim;
    longint inf;
    longint prev;
    longint sum;
    longint mean;
    longint unsigned sq;
    longint unsigned sd;
    longint d;
    int unsigned n;
    int unsigned idx;
    x = longint'($signed(smp)) * 256;
    stored = x;
    res = '0;
    if (first) begin
      ring_wr = 0;
      series_idx = 0;
      held_mean = 0;
      held_sd = 0;
    end
    n = (lag_cfg + 1 > RingDepth) ? RingDepth : lag_cfg + 1;
    if (series_idx > lag_cfg) begin
      diff = x - held_mean;
      mag = longint'(diff < 0 ? -diff : diff) * 256;
      lim = thr_cfg * held_sd;
      if (mag > lim) begin
        prev = filt_ring[(ring_wr + RingDepth - 1) % RingDepth];
        res.peak_signal = (x > held_mean) ? SigPos : SigNeg;
        inf = (inf_cfg > longint'(InfOne)) ? longint'(InfOne) : inf_cfg;
        stored = (inf * x + (longint'(InfOne) - inf) * prev) >>> 16;
      end
    end
    filt_ring[ring_wr] = stored;
    if (series_idx >= lag_cfg) begin
      sum = 0;
      for (int k = 0; k < n; k++) begin
        idx = (ring_wr + RingDepth - k) % RingDepth;
        sum += filt_ring[idx];
      end
      mean = sum / longint'(n);
      sq = 0;
      for (int k = 0; k < n; k++) begin
        idx = (ring_wr + RingDepth - k) % RingDepth;
        d = filt_ring[idx] - mean;
        sq += longint'(d * d);
      end
      sd = floor_root(sq / n);
      if (sd > 8388607) sd = 8388607;
      held_mean = mean;
      held_sd = sd;
      res.window_mean = mean[QBits-1:0];
      res.window_stddev = sd[SdBits-1:0];
      res.stats_valid = 1'b1;
    end
    ring_wr = (ring_wr + 1) % RingDepth;
    if (series_idx < 127) series_idx++;
    return res;
  endfunction

  task automatic send_word(int smp, bit first, bit typed, zpd_result_t typed_res);
    int gap;
    zpd_result_t want;
    gap = send_quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_s.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_s.valid <= 1'b1;
    in_s.data <= '{sample: smp[SampleBitsDef-1:0], first: first};
    @(posedge clk_i);
    while (!in_s.ready) @(posedge clk_i);
    want = next_peak_result(smp[SampleBitsDef-1:0], first);
    pending_results.push_back(typed ? typed_res : want);
  endtask

  task automatic drain_and_settle();
    in_s.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, int unsigned value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[CfgDataBits-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgLag: lag_cfg = value & 32'h3F;
      CfgThr: thr_cfg = value & 32'hFFFF;
      CfgInf: inf_cfg = value & 32'h1FFFF;
      default: ;
    endcase
  endtask

  task automatic apply_settings(int unsigned lag, int unsigned thr, int unsigned inf);
    write_reg(CfgLag, lag);
    write_reg(CfgThr, thr);
    write_reg(CfgInf, inf);
  endtask

  // noisy baseline with occasional spikes and rare restarts inside the run
  task automatic run_series(int count, bit restart);
    int level;
    int amp;
    int smp;
    bit first;
    level = $signed($urandom_range(0, 65535)) - 32768;
    level = level / 2;
    amp = $urandom_range(0, 3) == 0 ? 2000 : $urandom_range(1, 60);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) send_quiet = ($urandom_range(0, 3) == 0);
      first = (i == 0) ? restart : ($urandom_range(0, 60) == 0);
      case ($urandom_range(0, 19))
        0, 1: smp = level + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(500, 20000);
        2: smp = $signed($urandom_range(0, 65535)) - 32768;
        3: smp = $urandom_range(0, 1) ? 32767 : -32768;
        default: smp = level + $signed($urandom_range(0, 2 * amp)) - amp;
      endcase
      if (smp > 32767) smp = 32767;
      if (smp < -32768) smp = -32768;
      send_word(smp, first, 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin
    zpd_result_t got;
    zpd_result_t want;
    if (rst_ni && out_s.valid && out_s.ready) begin
      got = out_s.data;
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected word, peak_signal", got.peak_signal, 0);
      end else begin
        want = pending_results.pop_front();
        if (got.peak_signal !== want.peak_signal)
          flag_mismatch("peak_signal", got.peak_signal, want.peak_signal);
        if (got.window_mean !== want.window_mean)
          flag_mismatch("window_mean", $signed(got.window_mean), $signed(want.window_mean));
        if (got.window_stddev !== want.window_stddev)
          flag_mismatch("window_stddev", got.window_stddev, want.window_stddev);
        if (got.stats_valid !== want.stats_valid)
          flag_mismatch("stats_valid", got.stats_valid, want.stats_valid);
        if (want.peak_signal == SigPos) pos_peaks++;
        if (want.peak_signal == SigNeg) neg_peaks++;
        if (want.stats_valid) stats_words++;
      end
      words_checked++;
    end
  end

  initial begin
    int stall;
    bit quiet;
    out_s.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (($urandom_range(0, 49)) == 0) quiet = !quiet;
      stall = quiet ? 0 : $urandom_range(0, 5);
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        out_s.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_s.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_s.valid) @(posedge clk_i);
    end
  end

  function automatic zpd_result_t fixed_result(logic [1:0] sig, bit valid);
    zpd_result_t r;
    r = '0;
    r.peak_signal = sig;
    r.stats_valid = valid;
    return r;
  endfunction

  initial begin
    error_count = 0;
    words_checked = 0;
    pos_peaks = 0;
    neg_peaks = 0;
    stats_words = 0;
    hold_request = 0;
    send_quiet = 1'b0;
    lag_cfg = LagReset;
    thr_cfg = ThrReset;
    inf_cfg = InfReset;
    ring_wr = 0;
    series_idx = 0;
    held_mean = 0;
    held_sd = 0;
    foreach (filt_ring[i]) filt_ring[i] = '0;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_data_i <= '0;
    in_s.valid <= 1'b0;
    in_s.data <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: warm-up words under the default lag
    for (int i = 0; i < 4; i++)
      send_word(i == 0 ? 32767 : -32768, i == 0, 1'b1, fixed_result(SigNone, 1'b0));
    drain_and_settle();

    apply_settings(2, 256, 0);
    directed_rows = '{
      '{32767, 1'b1, 1'b1, fixed_result(SigNone, 1'b0)},
      '{-32768, 1'b0, 1'b1, fixed_result(SigNone, 1'b0)},
      '{0, 1'b0, 1'b0, '0},
      '{1, 1'b0, 1'b0, '0},
      '{-1, 1'b0, 1'b0, '0},
      '{0, 1'b1, 1'b1, fixed_result(SigNone, 1'b0)},
      '{0, 1'b0, 1'b1, fixed_result(SigNone, 1'b0)},
      '{0, 1'b0, 1'b1, fixed_result(SigNone, 1'b1)},
      '{0, 1'b0, 1'b1, fixed_result(SigNone, 1'b1)},
      '{100, 1'b0, 1'b1, fixed_result(SigPos, 1'b1)},
      '{-100, 1'b0, 1'b1, fixed_result(SigNeg, 1'b1)},
      '{32767, 1'b0, 1'b1, fixed_result(SigPos, 1'b1)},
      '{-32768, 1'b0, 1'b1, fixed_result(SigNeg, 1'b1)},
      '{21845, 1'b0, 1'b0, '0},
      '{-21846, 1'b0, 1'b0, '0},
      '{5, 1'b1, 1'b0, '0},
      '{7, 1'b0, 1'b0, '0},
      '{9, 1'b0, 1'b0, '0},
      '{10, 1'b0, 1'b0, '0},
      '{-4000, 1'b0, 1'b0, '0}
    };
    foreach (directed_rows[i])
      send_word(directed_rows[i].sample, directed_rows[i].first,
                directed_rows[i].typed, directed_rows[i].result);
    drain_and_settle();

    // lag grows mid-series, then a full series under the largest lag
    apply_settings(40, 768, 32768);
    run_series(50, 1'b0);
    drain_and_settle();

    apply_settings(63, 65535, 65536);
    run_series(80, 1'b1);
    drain_and_settle();

    // lag shrinks mid-series, influence above one
    apply_settings(3, 640, 131071);
    run_series(250, 1'b0);
    drain_and_settle();

    apply_settings(0, 1280, 16384);
    run_series(200, 1'b1);
    drain_and_settle();

    apply_settings(1, 0, 0);
    run_series(200, 1'b1);
    drain_and_settle();

    // receiver holds off while the sender keeps offering
    apply_settings(8, 512, 49152);
    hold_request = 1500;
    run_series(300, 1'b1);
    drain_and_settle();

    apply_settings(5, 384, 65535);
    run_series(300, 1'b1);
    drain_and_settle();

    apply_settings(16, 1024, 8192);
    run_series(250, 1'b1);
    drain_and_settle();

    $display("covered %0d words, %0d with stats, %0d rising and %0d falling peaks",
             words_checked, stats_words, pos_peaks, neg_peaks);
    $display("lags 0 to 63, threshold and influence extremes, restarts, output back-pressure");
    if (error_count == 0) begin
      $display("tb_zscore_peak_detector_unit: done, clean");
    end else begin
      $display("tb_zscore_peak_detector_unit: done, errors");
    end
    $finish;
  end

endmodule
